[rtl/mbrfb_pkg.sv]
// ----------------------------------------------------------------------------
// mbrfb_pkg
// Shared types, constants and CRC-16 helpers for the request frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrfb_pkg;

	localparam int unsigned BODY_BYTES = 5;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [7:0]  VALUE_ON = 8'h64;
	localparam logic [7:0]  REG_BASE = 8'h10;

	localparam logic [6:0]  GROUP_ONE  = 7'd1;
	localparam logic [6:0]  GROUP_TWO  = 7'd2;
	localparam logic [6:0]  GROUP_FOUR = 7'd4;

	localparam logic [7:0]  ID_GROUP_ONE   = 8'd1;
	localparam logic [7:0]  ID_GROUP_PAIR  = 8'd2;
	localparam logic [7:0]  ID_UNKNOWN     = 8'd0;
	localparam logic [7:0]  COUNT_ONE      = 8'd1;
	localparam logic [7:0]  COUNT_TWO      = 8'd2;

	// configuration register indexes
	localparam logic [7:0]  CFG_WRITE_CODE  = 8'd0;
	localparam logic [7:0]  CFG_READ_CODE   = 8'd1;
	localparam logic [7:0]  CFG_GROUP_TWO   = 8'd2;
	localparam logic [7:0]  CFG_GROUP_FOUR  = 8'd3;

	localparam logic [7:0]  RST_WRITE_CODE = 8'd6;
	localparam logic [7:0]  RST_READ_CODE  = 8'd3;
	localparam logic [7:0]  RST_GROUP_TWO  = 8'h22;
	localparam logic [7:0]  RST_GROUP_FOUR = 8'h20;

	// beat positions within a frame
	localparam logic [2:0]  POS_BYTE4 = 3'd4;
	localparam logic [2:0]  POS_BYTE5 = 3'd5;
	localparam logic [2:0]  POS_WR_LAST = 3'd6;
	localparam logic [2:0]  POS_RD_LAST = 3'd5;

	typedef struct packed {
		logic [7:0] write_code;
		logic [7:0] read_code;
		logic [7:0] group_two_register;
		logic [7:0] group_four_register;
	} cfg_t;

	typedef struct packed {
		logic                            wr;
		logic [BODY_BYTES-1:0][7:0]      body;
		logic [15:0]                     crc;
	} frame_t;

	// byte table of the reflected polynomial, one lookup per byte
	function automatic logic [15:0] crc_tab(input logic [7:0] idx);
		logic [15:0] c;
		c = {8'h00, idx};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic logic [15:0] crc_upd(input logic [15:0] crc, input logic [7:0] b);
		return {8'h00, crc[15:8]} ^ crc_tab(crc[7:0] ^ b);
	endfunction

endpackage

`default_nettype wire

[rtl/modbus_request_frame_builder.sv]
// ----------------------------------------------------------------------------
// modbus_request_frame_builder
// Builds a Modbus-style request frame per command and sends it byte by byte.
//
//   channel   direction  handshake                payload
//   cmd       in         cmd_valid / cmd_stall    mode, device_group,
//                                                 reg_number, set_value
//   frm       out        frm_valid / frm_stall    frame_byte, last_byte
//   cfg       in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A write command gives 7 beats, a read command 6; the byte serializer limits
// the sustained rate, and a waiting frame follows with no gap between frames.
// A command passes the input register, body build, two CRC stages and the
// frame register on its way to the first frame beat.
// Reset clears all valid flags and loads the configuration reset values.
// frm_stall holds the current beat; cmd_stall rises once the pipeline is full.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_request_frame_builder (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire logic               mode,
	input  wire logic [6:0]         device_group,
	input  wire logic [6:0]         reg_number,
	input  wire logic               set_value,
	output logic                    frm_valid,
	input  wire logic               frm_stall,
	output logic [7:0]              frame_byte,
	output logic                    last_byte,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [7:0]         cfg_index,
	input  wire logic [7:0]         cfg_data
);
	import mbrfb_pkg::*;

	cfg_t   cfg;
	logic   body_valid;
	frame_t body_frame;
	logic   body_take;
	logic   crc_valid;
	frame_t crc_frame;
	logic   crc_take;

	mbrfb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mbrfb_build u_build (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.mode         (mode),
		.device_group (device_group),
		.reg_number   (reg_number),
		.set_value    (set_value),
		.cfg          (cfg),
		.body_valid   (body_valid),
		.body_frame   (body_frame),
		.body_take    (body_take)
	);

	mbrfb_crc u_crc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (body_valid),
		.in_frame  (body_frame),
		.in_take   (body_take),
		.out_valid (crc_valid),
		.out_frame (crc_frame),
		.out_take  (crc_take)
	);

	mbrfb_ser u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (crc_valid),
		.in_frame   (crc_frame),
		.in_take    (crc_take),
		.frm_valid  (frm_valid),
		.frm_stall  (frm_stall),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule

`default_nettype wire

[rtl/mbrfb_cfg.sv]
// ----------------------------------------------------------------------------
// mbrfb_cfg
// Configuration register file: function codes and fixed sensor registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrfb_cfg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [7:0]         cfg_index,
	input  wire logic [7:0]         cfg_data,
	output mbrfb_pkg::cfg_t         cfg
);
	import mbrfb_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.write_code          <= RST_WRITE_CODE;
			cfg_q.read_code           <= RST_READ_CODE;
			cfg_q.group_two_register  <= RST_GROUP_TWO;
			cfg_q.group_four_register <= RST_GROUP_FOUR;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WRITE_CODE: cfg_q.write_code          <= cfg_data;
				CFG_READ_CODE:  cfg_q.read_code           <= cfg_data;
				CFG_GROUP_TWO:  cfg_q.group_two_register  <= cfg_data;
				CFG_GROUP_FOUR: cfg_q.group_four_register <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/mbrfb_build.sv]
// ----------------------------------------------------------------------------
// mbrfb_build
// Command input register and frame body assembly, with CRC over bytes 0 and 1.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrfb_build (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire logic               mode,
	input  wire logic [6:0]         device_group,
	input  wire logic [6:0]         reg_number,
	input  wire logic               set_value,
	input  wire mbrfb_pkg::cfg_t    cfg,
	output logic                    body_valid,
	output mbrfb_pkg::frame_t       body_frame,
	input  wire logic               body_take
);
	import mbrfb_pkg::*;

	logic       valid_s1;
	logic       mode_s1;
	logic [6:0] group_s1;
	logic [6:0] reg_s1;
	logic       setv_s1;

	logic       valid_s2;
	frame_t     frame_s2;

	logic       adv_s1;
	logic       adv_s2;
	logic       pair_grp;
	logic [7:0] calc_reg;
	frame_t     frame_d;

	assign adv_s2    = !valid_s2 || body_take;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign cmd_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && cmd_valid) begin
			mode_s1  <= mode;
			group_s1 <= device_group;
			reg_s1   <= reg_number;
			setv_s1  <= set_value;
		end
	end

	always_comb begin
		pair_grp = (group_s1 == GROUP_TWO) || (group_s1 == GROUP_FOUR);
		calc_reg = ({1'b0, reg_s1} | REG_BASE) - 8'd1;

		frame_d.wr = !mode_s1;
		if (group_s1 == GROUP_ONE) begin
			frame_d.body[0] = ID_GROUP_ONE;
		end else if (pair_grp) begin
			frame_d.body[0] = ID_GROUP_PAIR;
		end else begin
			frame_d.body[0] = ID_UNKNOWN;
		end

		if (!mode_s1) begin
			frame_d.body[1] = cfg.write_code;
			frame_d.body[2] = calc_reg;
			frame_d.body[3] = COUNT_ONE;
			frame_d.body[4] = setv_s1 ? VALUE_ON : 8'h00;
		end else begin
			frame_d.body[1] = cfg.read_code;
			frame_d.body[4] = 8'h00;
			if (group_s1 == GROUP_TWO) begin
				frame_d.body[2] = cfg.group_two_register;
				frame_d.body[3] = COUNT_TWO;
			end else if (group_s1 == GROUP_FOUR) begin
				frame_d.body[2] = cfg.group_four_register;
				frame_d.body[3] = COUNT_TWO;
			end else begin
				frame_d.body[2] = calc_reg;
				frame_d.body[3] = COUNT_ONE;
			end
		end

		frame_d.crc = crc_upd(crc_upd(CRC_INIT, frame_d.body[0]), frame_d.body[1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			frame_s2 <= frame_d;
		end
	end

	assign body_valid = valid_s2;
	assign body_frame = frame_s2;

endmodule

`default_nettype wire

[rtl/mbrfb_crc.sv]
// ----------------------------------------------------------------------------
// mbrfb_crc
// Finishes the CRC-16 over the remaining body bytes in two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrfb_crc (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire mbrfb_pkg::frame_t  in_frame,
	output logic                    in_take,
	output logic                    out_valid,
	output mbrfb_pkg::frame_t       out_frame,
	input  wire logic               out_take
);
	import mbrfb_pkg::*;

	logic   valid_s3;
	frame_t frame_s3;
	logic   valid_s4;
	frame_t frame_s4;

	logic   adv_s3;
	logic   adv_s4;
	frame_t frame_d3;
	frame_t frame_d4;

	assign adv_s4  = !valid_s4 || out_take;
	assign adv_s3  = !valid_s3 || adv_s4;
	assign in_take = adv_s3;

	always_comb begin
		frame_d3     = in_frame;
		frame_d3.crc = crc_upd(crc_upd(in_frame.crc, in_frame.body[2]), in_frame.body[3]);
	end

	// byte 4 belongs to the body only for write frames
	always_comb begin
		frame_d4 = frame_s3;
		if (frame_s3.wr) begin
			frame_d4.crc = crc_upd(frame_s3.crc, frame_s3.body[4]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv_s3) begin
				valid_s3 <= in_valid;
			end
			if (adv_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && in_valid) begin
			frame_s3 <= frame_d3;
		end
		if (adv_s4 && valid_s3) begin
			frame_s4 <= frame_d4;
		end
	end

	assign out_valid = valid_s4;
	assign out_frame = frame_s4;

endmodule

`default_nettype wire

[rtl/mbrfb_ser.sv]
// ----------------------------------------------------------------------------
// mbrfb_ser
// Frame register and byte serializer: one beat per frame byte, CRC high first.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrfb_ser (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire mbrfb_pkg::frame_t  in_frame,
	output logic                    in_take,
	output logic                    frm_valid,
	input  wire logic               frm_stall,
	output logic [7:0]              frame_byte,
	output logic                    last_byte
);
	import mbrfb_pkg::*;

	logic       busy_q;
	frame_t     frame_q;
	logic [2:0] idx_q;

	logic       beat;
	logic       done;

	assign last_byte = (idx_q == (frame_q.wr ? POS_WR_LAST : POS_RD_LAST));
	assign beat      = busy_q && !frm_stall;
	assign done      = beat && last_byte;
	// next frame loads on the cycle the last beat goes out
	assign in_take   = !busy_q || done;
	assign frm_valid = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 3'd0;
		end else if (in_take && in_valid) begin
			busy_q <= 1'b1;
			idx_q  <= 3'd0;
		end else if (done) begin
			busy_q <= 1'b0;
			idx_q  <= 3'd0;
		end else if (beat) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && in_valid) begin
			frame_q <= in_frame;
		end
	end

	always_comb begin
		case (idx_q)
			3'd0, 3'd1, 3'd2, 3'd3: frame_byte = frame_q.body[idx_q];
			POS_BYTE4: frame_byte = frame_q.wr ? frame_q.body[4] : frame_q.crc[15:8];
			POS_BYTE5: frame_byte = frame_q.wr ? frame_q.crc[15:8] : frame_q.crc[7:0];
			default:   frame_byte = frame_q.crc[7:0];
		endcase
	end

endmodule

`default_nettype wire

[tb/frame_check_pkg.sv]
// ----------------------------------------------------------------------------
// frame_check_pkg
// Expected-frame tracker for the request frame builder testbench: keeps its
// own copy of the configuration registers, builds the byte sequence that
// each accepted command must produce and compares output beats in order.
// ----------------------------------------------------------------------------
`default_nettype none

package frame_check_pkg;

	import mbrfb_pkg::*;

	localparam logic        MODE_WRITE = 1'b0;
	localparam logic        MODE_READ  = 1'b1;

	// indexes past the register file, writes there must be ignored
	localparam logic [7:0]  CFG_FIRST_UNUSED = 8'd4;
	localparam logic [7:0]  CFG_LAST_INDEX   = 8'hFF;

	localparam logic [15:0] MODBUS_CRC_SEED = 16'hFFFF;
	localparam logic [15:0] MODBUS_CRC_POLY = 16'hA001;
	localparam logic [7:0]  VALUE_OFF       = 8'h00;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} frame_beat_t;

	class request_frame_checker;
		logic [7:0]  write_code;
		logic [7:0]  read_code;
		logic [7:0]  group_two_reg;
		logic [7:0]  group_four_reg;
		frame_beat_t expected_beats[$];
		int          mismatches;

		function new();
			mismatches = 0;
			write_code = RST_WRITE_CODE;
			read_code = RST_READ_CODE;
			group_two_reg = RST_GROUP_TWO;
			group_four_reg = RST_GROUP_FOUR;
		endfunction

		function void set_register(input logic [7:0] idx, input logic [7:0] data);
			case (idx)
				CFG_WRITE_CODE: begin
					write_code = data;
				end
				CFG_READ_CODE: begin
					read_code = data;
				end
				CFG_GROUP_TWO: begin
					group_two_reg = data;
				end
				CFG_GROUP_FOUR: begin
					group_four_reg = data;
				end
				default: begin
				end
			endcase
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		// queue up the whole frame one accepted command must produce
		function void note_command(input logic m, input logic [6:0] group,
				input logic [6:0] regnum, input logic setv);
			logic [7:0]  body[5];
			logic [7:0]  reg_byte;
			logic [15:0] crc;
			int          body_len;
			frame_beat_t beat;

			reg_byte = (REG_BASE | {1'b0, regnum}) - 8'd1;
			if (group == GROUP_ONE) begin
				body[0] = ID_GROUP_ONE;
			end else if (group == GROUP_TWO || group == GROUP_FOUR) begin
				body[0] = ID_GROUP_PAIR;
			end else begin
				body[0] = ID_UNKNOWN;
			end
			body[4] = VALUE_OFF;
			if (m == MODE_WRITE) begin
				body[1] = write_code;
				body[2] = reg_byte;
				body[3] = COUNT_ONE;
				body[4] = setv ? VALUE_ON : VALUE_OFF;
				body_len = 5;
			end else begin
				body[1] = read_code;
				if (group == GROUP_TWO) begin
					body[2] = group_two_reg;
					body[3] = COUNT_TWO;
				end else if (group == GROUP_FOUR) begin
					body[2] = group_four_reg;
					body[3] = COUNT_TWO;
				end else begin
					body[2] = reg_byte;
					body[3] = COUNT_ONE;
				end
				body_len = 4;
			end

			// bitwise crc-16, reflected
			crc = MODBUS_CRC_SEED;
			for (int k = 0; k < body_len; k++) begin
				crc = crc ^ {8'h00, body[k]};
				for (int b = 0; b < 8; b++) begin
					crc = crc[0] ? ((crc >> 1) ^ MODBUS_CRC_POLY) : (crc >> 1);
				end
			end

			for (int k = 0; k < body_len; k++) begin
				beat.frame_byte = body[k];
				beat.last_byte = 1'b0;
				expected_beats.push_back(beat);
			end
			// high byte goes out first
			beat.frame_byte = crc[15:8];
			beat.last_byte = 1'b0;
			expected_beats.push_back(beat);
			beat.frame_byte = crc[7:0];
			beat.last_byte = 1'b1;
			expected_beats.push_back(beat);
		endfunction

		function void check_beat(input logic [7:0] got_byte, input logic got_last);
			frame_beat_t want;
			if (expected_beats.size() == 0) begin
				$error("unexpected frame beat: frame_byte %02h last_byte %0b",
					got_byte, got_last);
				mismatches++;
				return;
			end
			want = expected_beats.pop_front();
			if (got_byte !== want.frame_byte) begin
				$error("frame_byte mismatch: expected %02h, actual %02h",
					want.frame_byte, got_byte);
				mismatches++;
			end
			if (got_last !== want.last_byte) begin
				$error("last_byte mismatch: expected %0b, actual %0b",
					want.last_byte, got_last);
				mismatches++;
			end
		endfunction
	endclass

endpackage

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives commands and register writes into the request frame builder and
// checks every output beat against frames built independently here. A short
// directed set covers groups, modes and register edge values, then random
// phases run under different register settings and idle/stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	import mbrfb_pkg::*;
	import frame_check_pkg::*;

	localparam int QUIET_LIMIT     = 4000;
	localparam int DRAIN_CYCLES    = 12;
	localparam int PHASE_COMMANDS  = 54;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_stall;
	logic       mode = 1'b0;
	logic [6:0] device_group = '0;
	logic [6:0] reg_number = '0;
	logic       set_value = 1'b0;
	logic       frm_valid;
	logic       frm_stall = 1'b0;
	logic [7:0] frame_byte;
	logic       last_byte;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	request_frame_checker frames = new();

	modbus_request_frame_builder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.mode         (mode),
		.device_group (device_group),
		.reg_number   (reg_number),
		.set_value    (set_value),
		.frm_valid    (frm_valid),
		.frm_stall    (frm_stall),
		.frame_byte   (frame_byte),
		.last_byte    (last_byte),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		frm_stall <= ($urandom_range(99) < recv_stall_pct);
		if (frm_valid === 1'b1 && frm_stall === 1'b0) begin
			frames.check_beat(frame_byte, last_byte);
		end
	end

	// ends the run when no beat of any channel has moved for too long
	initial begin
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (frm_valid && !frm_stall)
					|| (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("tb: failure");
		$finish;
	end

	task automatic send_command(input logic m, input logic [6:0] group,
			input logic [6:0] regnum, input logic setv);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		mode <= m;
		device_group <= group;
		reg_number <= regnum;
		set_value <= setv;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		frames.note_command(m, group, regnum, setv);
	endtask

	task automatic send_random_command();
		logic [6:0] group;
		case ($urandom_range(3))
			0: group = GROUP_ONE;
			1: group = GROUP_TWO;
			2: group = GROUP_FOUR;
			default: group = 7'($urandom_range(127));
		endcase
		send_command(1'($urandom_range(1)), group, 7'($urandom_range(127)),
			1'($urandom_range(1)));
	endtask

	// lower valid, then hold until every queued frame byte is out
	task automatic drain_frames();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (frames.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_register(input logic [7:0] idx, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		frames.set_register(idx, data);
	endtask

	task automatic load_registers(input logic [7:0] wr, input logic [7:0] rd,
			input logic [7:0] two, input logic [7:0] four);
		write_register(CFG_WRITE_CODE, wr);
		write_register(CFG_READ_CODE, rd);
		write_register(CFG_GROUP_TWO, two);
		write_register(CFG_GROUP_FOUR, four);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: groups, both modes, register number edges
		send_command(MODE_WRITE, GROUP_ONE, 7'd1, 1'b1);
		send_command(MODE_WRITE, GROUP_ONE, 7'd1, 1'b0);
		send_command(MODE_READ, GROUP_ONE, 7'd5, 1'b0);
		send_command(MODE_READ, GROUP_TWO, 7'd3, 1'b1);
		send_command(MODE_READ, GROUP_FOUR, 7'd3, 1'b0);
		send_command(MODE_WRITE, GROUP_TWO, 7'd16, 1'b1);
		send_command(MODE_WRITE, GROUP_FOUR, 7'd15, 1'b0);
		send_command(MODE_WRITE, 7'd0, 7'd0, 1'b1);
		send_command(MODE_READ, 7'd0, 7'd0, 1'b0);
		send_command(MODE_READ, 7'd3, 7'd99, 1'b1);
		send_command(MODE_WRITE, 7'd99, 7'd99, 1'b1);
		send_command(MODE_READ, 7'd127, 7'd127, 1'b1);
		send_command(MODE_WRITE, 7'd127, 7'd127, 1'b0);
		send_command(MODE_WRITE, GROUP_ONE, 7'd127, 1'b1);
		send_command(MODE_READ, GROUP_ONE, 7'd0, 1'b1);
		send_command(MODE_READ, 7'd5, 7'd42, 1'b0);

		for (int phase = 0; phase < 4; phase++) begin
			drain_frames();
			repeat (DRAIN_CYCLES) @(posedge clk);
			case (phase)
				0: load_registers(8'h00, 8'h00, 8'h00, 8'h00);
				1: load_registers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
				2: begin
					load_registers(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
					// out-of-range indexes change nothing
					write_register(CFG_FIRST_UNUSED, 8'($urandom));
					write_register(CFG_LAST_INDEX, 8'($urandom));
				end
				default: load_registers(8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom));
			endcase
			cfg_valid <= 1'b0;
			@(posedge clk);
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 63;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 63;
				end
				default: begin
					send_idle_pct = 15;
					recv_stall_pct = 15;
				end
			endcase
			for (int n = 0; n < PHASE_COMMANDS; n++) begin
				if (n == PHASE_COMMANDS / 2) begin
					drain_frames();
				end
				send_random_command();
			end
		end

		drain_frames();
		recv_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (frames.mismatches == 0 && frames.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire
